// ===== sv/bsa_pkg.sv =====
// shared types, opcodes and constants of the baseline stack accumulator
package bsa_pkg;

	// input opcodes
	localparam logic [1:0] OP_FLAG = 2'd0;
	localparam logic [1:0] OP_ACC  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// divider step counts
	localparam logic [6:0] DIV_STEPS_IW   = 7'd33;
	localparam logic [6:0] DIV_STEPS_FULL = 7'd64;

	// saturation limits
	localparam logic [63:0] MEAN_MAX = 64'd549755813887;
	localparam logic [63:0] MEAN_NEG = 64'd549755813888;
	localparam logic [63:0] MASK48   = 64'hFFFF_FFFF_FFFF;

	// one stack entry as stored in memory
	typedef struct packed {
		logic [15:0] cnt;
		logic [47:0] siw;
		logic [63:0] v2;
		logic [47:0] si;
		logic [47:0] sr;
	} entry_t;

	// divider request and response
	typedef struct packed {
		logic        start;
		logic [6:0]  steps;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] quo;
	} div_rsp_t;

	// rounded quotient magnitude to signed 40-bit mean with saturation
	function automatic logic [39:0] q_mean(input logic [63:0] q, input logic neg);
		logic [63:0] qs;
		begin
			if (neg) begin
				qs = (q > MEAN_NEG) ? MEAN_NEG : q;
				q_mean = 40'(~qs[39:0] + 40'd1);
			end else begin
				qs = (q > MEAN_MAX) ? MEAN_MAX : q;
				q_mean = qs[39:0];
			end
		end
	endfunction

endpackage

// ===== sv/bsa_mul.sv =====
// registered 24x24 unsigned multiplier shared by all squaring steps
module bsa_mul (
	input  logic        clk,
	input  logic [23:0] a,
	input  logic [23:0] b,
	output logic [47:0] p
);

	logic [47:0] p_q;

	// product register
	always_ff @(posedge clk) begin
		p_q <= 48'(a) * 48'(b);
	end

	assign p = p_q;

endmodule

// ===== sv/bsa_div.sv =====
// restoring divider, one quotient bit per cycle, 128-bit dividend, saturating quotient
module bsa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bsa_pkg::div_req_t  req,
	output bsa_pkg::div_rsp_t  rsp
);

	logic        busy_q;
	logic        done_q;
	logic [6:0]  cnt_q;
	logic [63:0] r_q;
	logic [63:0] q_q;
	logic [63:0] lo_q;
	logic [63:0] d_q;

	logic        carry;
	logic [63:0] rs;
	logic        ge;
	logic [63:0] rn;
	logic        quick;

	// one shift-compare-subtract step
	assign carry = r_q[63];
	assign rs    = {r_q[62:0], lo_q[63]};
	assign ge    = carry || (rs >= d_q);
	assign rn    = ge ? (rs - d_q) : rs;

	// zero divisor or quotient overflow finish at once
	assign quick = (req.den == 64'd0) || (req.hi >= req.den);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (quick) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= req.steps;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			r_q  <= req.hi;
			lo_q <= req.lo;
			d_q  <= req.den;
			if (req.den == 64'd0) begin
				q_q <= '0;
			end else if (req.hi >= req.den) begin
				q_q <= '1;
			end else begin
				q_q <= '0;
			end
		end else if (busy_q) begin
			r_q  <= rn;
			lo_q <= {lo_q[62:0], 1'b0};
			q_q  <= {q_q[62:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = q_q;

endmodule

// ===== sv/baseline_stack_accumulator.sv =====
// top level: stack memory, flag memory, sequencer and result register
//
//  channel | dir | handshake         | payload
//  s_      | in  | tvalid/tready     | tdata fields, tuser opcode, tlast last_stack
//  m_      | out | tvalid/tready     | tdata result fields, tlast residual_valid
//
// after reset a clearing pass over max(NUM_INPUTS, NUM_STACKS) addresses sets all
// flags good and all stack entries to zero; no input is taken meanwhile.
// one item at a time: a flag write, an accumulate that waits for the 33-step
// reciprocal in the divider, or a readout with four or five 64-step divisions
// on the shared divider, the fifth only on the last readout.
// a finished result waits in the output register while the next item is taken.
module baseline_stack_accumulator #(
	parameter int NUM_STACKS = 1024,
	parameter int NUM_INPUTS = 2048
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// vis_re[23:0] vis_im[47:24] weight[79:48] input_a[90:80] input_b[101:91]
	// flag_good[102] stack_index[112:103] conjugate[113], zero pad
	input  logic [119:0] s_tdata,
	// opcode
	input  logic [1:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// stack_id[9:0] mean_re[49:10] mean_im[89:50] stack_weight[137:90]
	// stack_count[153:138] residual[201:154], zero pad
	output logic [207:0] m_tdata,
	output logic         m_tlast
);

	localparam int FAW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int SAW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int CLR_DEPTH = (NUM_INPUTS > NUM_STACKS) ? NUM_INPUTS : NUM_STACKS;
	localparam int CLW = $clog2(CLR_DEPTH + 1);

	typedef enum logic [10:0] {
		ST_CLEAR   = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_DECODE  = 11'b000_0000_0100,
		ST_FLAG_A  = 11'b000_0000_1000,
		ST_FLAG_B  = 11'b000_0001_0000,
		ST_ACC_MUL = 11'b000_0010_0000,
		ST_ACC_WR  = 11'b000_0100_0000,
		ST_RD_LOAD = 11'b000_1000_0000,
		ST_MUL     = 11'b001_0000_0000,
		ST_DIV     = 11'b010_0000_0000,
		ST_OUT     = 11'b100_0000_0000
	} state_t;

	state_t state_q;
	logic [CLW-1:0] clr_q;

	// captured item
	logic [1:0]  op_q;
	logic [23:0] re_q;
	logic [23:0] im_q;
	logic [31:0] wt_q;
	logic [10:0] ia_q;
	logic [10:0] ib_q;
	logic        fg_q;
	logic [9:0]  idx_q;
	logic        cj_q;
	logic        last_q;

	// work registers
	logic             ga_q;
	logic [48:0]      sq_q;
	bsa_pkg::entry_t  ent_q;
	logic [2:0]       mk_q;
	logic [95:0]      sq96_q;
	logic [31:0]      nn_q;
	logic [2:0]       dk_q;
	logic             dwait_q;
	logic [39:0]      mre_q;
	logic [39:0]      mim_q;
	logic [47:0]      wgt_q;
	logic [47:0]      res_q;
	logic [63:0]      rvt_q;
	logic [31:0]      rct_q;

	// output register
	logic         m_tvalid_q;
	logic [207:0] m_tdata_q;
	logic         m_tlast_q;

	// memories
	logic             fl_mem [NUM_INPUTS];
	logic             fl_we;
	logic             fl_re;
	logic [FAW-1:0]   fl_addr;
	logic             fl_wdata;
	logic             fl_rdata_q;

	bsa_pkg::entry_t  st_mem [NUM_STACKS];
	logic             st_we;
	logic             st_re;
	logic [SAW-1:0]   st_addr;
	bsa_pkg::entry_t  st_wdata;
	bsa_pkg::entry_t  st_rdata_q;

	// shared units
	logic [23:0]        mul_a;
	logic [23:0]        mul_b;
	logic [47:0]        mul_p;
	bsa_pkg::div_req_t  div_req;
	bsa_pkg::div_rsp_t  div_rsp;

	// range checks
	logic ia_ok;
	logic ib_ok;
	logic idx_ok;
	logic clr_fl;
	logic clr_st;
	logic accept;
	logic gb;
	logic out_free;

	assign ia_ok  = ({21'd0, ia_q} < 32'(NUM_INPUTS));
	assign ib_ok  = ({21'd0, ib_q} < 32'(NUM_INPUTS));
	assign idx_ok = ({22'd0, idx_q} < 32'(NUM_STACKS));
	assign clr_fl = (32'(clr_q) < 32'(NUM_INPUTS));
	assign clr_st = (32'(clr_q) < 32'(NUM_STACKS));
	assign gb     = !ib_ok || fl_rdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// magnitudes for squaring
	logic [23:0] re_abs;
	logic [23:0] im_abs;
	logic [47:0] ar;
	logic [47:0] ai;

	assign re_abs = re_q[23] ? 24'(~re_q + 24'd1) : re_q;
	assign im_abs = im_q[23] ? 24'(~im_q + 24'd1) : im_q;
	assign ar = ent_q.sr[47] ? 48'(~ent_q.sr + 48'd1) : ent_q.sr;
	assign ai = ent_q.si[47] ? 48'(~ent_q.si + 48'd1) : ent_q.si;

	// accumulated entry
	logic [24:0]      imc;
	logic [48:0]      sr_sum;
	logic [48:0]      si_sum;
	logic [64:0]      v2_sum;
	logic [48:0]      iw_sum;
	bsa_pkg::entry_t  acc_entry;

	assign imc    = cj_q ? 25'(~{im_q[23], im_q} + 25'd1) : {im_q[23], im_q};
	assign sr_sum = {st_rdata_q.sr[47], st_rdata_q.sr} + {{25{re_q[23]}}, re_q};
	assign si_sum = {st_rdata_q.si[47], st_rdata_q.si} + {{24{imc[24]}}, imc};
	assign v2_sum = {1'b0, st_rdata_q.v2} + 65'(sq_q);
	assign iw_sum = {1'b0, st_rdata_q.siw} + 49'(div_rsp.quo[32:0]);

	always_comb begin
		if (sr_sum[48] != sr_sum[47]) begin
			acc_entry.sr = sr_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_entry.sr = sr_sum[47:0];
		end
		if (si_sum[48] != si_sum[47]) begin
			acc_entry.si = si_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			acc_entry.si = si_sum[47:0];
		end
		acc_entry.v2  = v2_sum[64] ? '1 : v2_sum[63:0];
		acc_entry.siw = iw_sum[48] ? '1 : iw_sum[47:0];
		acc_entry.cnt = (&st_rdata_q.cnt) ? st_rdata_q.cnt : st_rdata_q.cnt + 16'd1;
	end

	// residual contribution and totals
	logic [63:0] contrib;
	logic [64:0] rvt_sum;
	logic [32:0] rct_sum;

	assign contrib = (ent_q.v2 > div_rsp.quo) ? (ent_q.v2 - div_rsp.quo) : 64'd0;
	assign rvt_sum = {1'b0, rvt_q} + {1'b0, contrib};
	assign rct_sum = {1'b0, rct_q} + 33'(ent_q.cnt);

	// memory port selection
	always_comb begin
		fl_we    = 1'b0;
		fl_re    = 1'b0;
		fl_addr  = FAW'(ia_q);
		fl_wdata = fg_q;
		st_we    = 1'b0;
		st_re    = 1'b0;
		st_addr  = SAW'(idx_q);
		st_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				fl_we    = clr_fl;
				fl_addr  = FAW'(clr_q);
				fl_wdata = 1'b1;
				st_we    = clr_st;
				st_addr  = SAW'(clr_q);
			end
			ST_DECODE: begin
				fl_we = (op_q == bsa_pkg::OP_FLAG) && ia_ok;
				fl_re = (op_q == bsa_pkg::OP_ACC);
				st_re = (op_q == bsa_pkg::OP_READ) && idx_ok;
			end
			ST_FLAG_A: begin
				fl_re   = 1'b1;
				fl_addr = FAW'(ib_q);
			end
			ST_FLAG_B: begin
				st_re = ga_q && gb;
			end
			ST_ACC_WR: begin
				st_we    = div_rsp.done;
				st_wdata = acc_entry;
			end
			ST_RD_LOAD: begin
				st_we = idx_ok;
			end
			default: begin
			end
		endcase
	end

	// flag memory
	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_addr] <= fl_wdata;
		end
		if (fl_re) begin
			fl_rdata_q <= fl_mem[fl_addr];
		end
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_addr] <= st_wdata;
		end
		if (st_re) begin
			st_rdata_q <= st_mem[st_addr];
		end
	end

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_FLAG_B) begin
			mul_a = re_abs;
			mul_b = re_abs;
		end else if (state_q == ST_ACC_MUL) begin
			mul_a = im_abs;
			mul_b = im_abs;
		end else if (state_q == ST_MUL) begin
			case (mk_q)
				3'd0: begin
					mul_a = {8'd0, ent_q.cnt};
					mul_b = {8'd0, ent_q.cnt};
				end
				3'd1: begin
					mul_a = ar[23:0];
					mul_b = ar[23:0];
				end
				3'd2: begin
					mul_a = ar[23:0];
					mul_b = ar[47:24];
				end
				3'd3: begin
					mul_a = ar[47:24];
					mul_b = ar[47:24];
				end
				3'd4: begin
					mul_a = ai[23:0];
					mul_b = ai[23:0];
				end
				3'd5: begin
					mul_a = ai[23:0];
					mul_b = ai[47:24];
				end
				3'd6: begin
					mul_a = ai[47:24];
					mul_b = ai[47:24];
				end
				default: begin
				end
			endcase
		end
	end

	bsa_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// divider requests
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = bsa_pkg::DIV_STEPS_FULL;
		div_req.hi    = '0;
		div_req.lo    = '0;
		div_req.den   = 64'(ent_q.cnt);
		if (state_q == ST_FLAG_B) begin
			div_req.start = ga_q && gb;
			div_req.steps = bsa_pkg::DIV_STEPS_IW;
			div_req.lo    = {1'b1, 63'd0};
			div_req.den   = 64'(wt_q);
		end else if (state_q == ST_DIV) begin
			div_req.start = !dwait_q;
			case (dk_q)
				3'd0: div_req.lo = {ar[47:0], 16'd0} + 64'(ent_q.cnt[15:1]);
				3'd1: div_req.lo = {ai[47:0], 16'd0} + 64'(ent_q.cnt[15:1]);
				3'd2: begin
					div_req.lo  = {nn_q, 32'd0};
					div_req.den = 64'(ent_q.siw);
				end
				3'd3: begin
					div_req.hi = {32'd0, sq96_q[95:64]};
					div_req.lo = sq96_q[63:0];
				end
				default: begin
					div_req.hi  = 64'(rvt_q[63:48]);
					div_req.lo  = {rvt_q[47:0], 16'd0};
					div_req.den = 64'(rct_q);
				end
			endcase
		end
	end

	bsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			mk_q       <= '0;
			dk_q       <= '0;
			dwait_q    <= 1'b0;
			rvt_q      <= '0;
			rct_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output valid: set by a new result, cleared by its transfer
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (clr_q == CLW'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (op_q)
						bsa_pkg::OP_ACC: begin
							state_q <= (wt_q != 32'd0 && idx_ok) ? ST_FLAG_A : ST_IDLE;
						end
						bsa_pkg::OP_READ: state_q <= ST_RD_LOAD;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_FLAG_A: state_q <= ST_FLAG_B;
				ST_FLAG_B: begin
					mk_q    <= '0;
					state_q <= (ga_q && gb) ? ST_ACC_MUL : ST_IDLE;
				end
				ST_ACC_MUL: begin
					mk_q <= mk_q + 3'd1;
					if (mk_q == 3'd1) begin
						state_q <= ST_ACC_WR;
					end
				end
				ST_ACC_WR: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_LOAD: begin
					mk_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mk_q <= mk_q + 3'd1;
					if (mk_q == 3'd7) begin
						dk_q    <= '0;
						dwait_q <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!dwait_q) begin
						dwait_q <= 1'b1;
					end else if (div_rsp.done) begin
						dwait_q <= 1'b0;
						dk_q    <= dk_q + 3'd1;
						if (dk_q == 3'd3) begin
							rvt_q <= rvt_sum[64] ? '1 : rvt_sum[63:0];
							rct_q <= rct_sum[32] ? '1 : rct_sum[31:0];
							if (!last_q) begin
								state_q <= ST_OUT;
							end
						end else if (dk_q == 3'd4) begin
							rvt_q   <= '0;
							rct_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			re_q   <= s_tdata[23:0];
			im_q   <= s_tdata[47:24];
			wt_q   <= s_tdata[79:48];
			ia_q   <= s_tdata[90:80];
			ib_q   <= s_tdata[101:91];
			fg_q   <= s_tdata[102];
			idx_q  <= s_tdata[112:103];
			cj_q   <= s_tdata[113];
			last_q <= s_tlast;
		end
		if (state_q == ST_FLAG_A) begin
			ga_q <= !ia_ok || fl_rdata_q;
		end
		// squared magnitude of the product
		if (state_q == ST_ACC_MUL) begin
			if (mk_q == 3'd0) begin
				sq_q <= 49'(mul_p);
			end else begin
				sq_q <= sq_q + 49'(mul_p);
			end
		end
		// entry capture on readout
		if (state_q == ST_RD_LOAD) begin
			ent_q  <= idx_ok ? st_rdata_q : '0;
			sq96_q <= '0;
		end
		// partial products of the squared sums
		if (state_q == ST_MUL) begin
			case (mk_q)
				3'd1: nn_q <= mul_p[31:0];
				3'd2: sq96_q <= sq96_q + 96'(mul_p);
				3'd3: sq96_q <= sq96_q + (96'(mul_p) << 25);
				3'd4: sq96_q <= sq96_q + (96'(mul_p) << 48);
				3'd5: sq96_q <= sq96_q + 96'(mul_p);
				3'd6: sq96_q <= sq96_q + (96'(mul_p) << 25);
				3'd7: sq96_q <= sq96_q + (96'(mul_p) << 48);
				default: begin
				end
			endcase
		end
		// division results
		if (state_q == ST_DIV && dwait_q && div_rsp.done) begin
			case (dk_q)
				3'd0: mre_q <= bsa_pkg::q_mean(div_rsp.quo, ent_q.sr[47]);
				3'd1: mim_q <= bsa_pkg::q_mean(div_rsp.quo, ent_q.si[47]);
				3'd2: begin
					wgt_q <= (div_rsp.quo > bsa_pkg::MASK48) ? '1 : div_rsp.quo[47:0];
				end
				3'd3: res_q <= '0;
				default: begin
					res_q <= (div_rsp.quo > bsa_pkg::MASK48) ? '1 : div_rsp.quo[47:0];
				end
			endcase
		end
		// result transfer into the output register
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {6'd0, res_q, ent_q.cnt, wgt_q, mim_q, mre_q, idx_q};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// divider is only started when idle
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	// single-port stack memory
	a_st_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_we && st_re))
		else $error("stack memory read and write in one cycle");

	// accumulate write-back waits for the reciprocal
	a_acc_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && state_q == ST_ACC_WR) |-> div_rsp.done)
		else $error("accumulate write-back before reciprocal done");

	// residual totals are cleared before the last result goes out
	a_res_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && last_q) |-> (rvt_q == 64'd0 && rct_q == 32'd0))
		else $error("residual totals not cleared on last readout");

endmodule

// ===== sim/baseline_stack_accumulator_tb.sv =====
// self-checking testbench of the baseline stack accumulator
module baseline_stack_accumulator_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [63:0] ALL64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint SUM48_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint SUM48_MIN = -64'sh8000_0000_0000;

	// one readout result
	typedef struct packed {
		logic [9:0]  id;
		logic [39:0] mre;
		logic [39:0] mim;
		logic [47:0] wgt;
		logic [15:0] cnt;
		logic [47:0] res;
		logic        rv;
	} stack_result_t;

	// one input item, with an optional typed-in readout result
	typedef struct packed {
		logic [1:0]    op;
		logic [23:0]   re;
		logic [23:0]   im;
		logic [31:0]   w;
		logic [10:0]   a;
		logic [10:0]   b;
		logic          fg;
		logic [9:0]    idx;
		logic          conj;
		logic          last;
		logic          typed;
		stack_result_t exp;
	} bsa_item_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [119:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [207:0] m_tdata;
	logic m_tlast;

	// typed-in expectation travels with the item being offered
	logic cur_typed;
	stack_result_t cur_exp;

	// predictor state
	bit flag_ok [2048];
	longint stack_sr [1024];
	longint stack_si [1024];
	bit [63:0] stack_msq [1024];
	bit [63:0] stack_siw [1024];
	bit [15:0] stack_cnt [1024];
	bit [63:0] resid_total;
	bit [31:0] resid_cnt;

	stack_result_t pending_results[$];
	bsa_item_t directed_rows[$];
	int mismatches = 0;
	int items_taken = 0;
	longint unsigned cycles = 0;

	baseline_stack_accumulator uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic longint sat48(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > SUM48_MAX) return SUM48_MAX;
		if (s < SUM48_MIN) return SUM48_MIN;
		return s;
	endfunction

	// rounded Q.16 mean, half away from zero, saturated to 40 bits
	function automatic logic [39:0] mean_q16(input longint s, input bit [63:0] n);
		bit [63:0] mag, q;
		if (n == 0) return '0;
		mag = (s < 0) ? -s : s;
		q = (mag * 64'd65536 + n / 2) / n;
		if (s < 0) begin
			if (q > bsa_pkg::MEAN_NEG) q = bsa_pkg::MEAN_NEG;
			return -q[39:0];
		end
		if (q > bsa_pkg::MEAN_MAX) q = bsa_pkg::MEAN_MAX;
		return q[39:0];
	endfunction

	// product accumulation into a stack entry
	function automatic void accumulate(input logic signed [23:0] vre, input logic signed [23:0] vim,
			input logic [31:0] w, input logic [10:0] a, input logic [10:0] b,
			input logic [9:0] idx, input logic conj);
		longint re, im;
		bit [64:0] v2s;
		bit [63:0] iw, siw;
		re = vre;
		im = vim;
		if (w == 0 || !flag_ok[a] || !flag_ok[b]) return;
		if (conj) im = -im;
		stack_sr[idx] = sat48(stack_sr[idx], re);
		stack_si[idx] = sat48(stack_si[idx], im);
		v2s = {1'b0, stack_msq[idx]} + 65'(64'(re * re) + 64'(im * im));
		stack_msq[idx] = v2s[64] ? ALL64 : v2s[63:0];
		iw = 64'h1_0000_0000 / w;
		siw = stack_siw[idx] + iw;
		stack_siw[idx] = (siw > bsa_pkg::MASK48) ? bsa_pkg::MASK48 : siw;
		if (stack_cnt[idx] != 16'hFFFF) stack_cnt[idx]++;
	endfunction

	// readout: means, weight, residual totals, clear of the entry
	function automatic stack_result_t read_stack(input logic [9:0] idx, input logic last);
		stack_result_t r;
		bit [63:0] n, siw, v2, q, contrib;
		bit [127:0] wide, ar, ai;
		bit [64:0] tsum;
		bit [32:0] csum;
		n = stack_cnt[idx];
		siw = stack_siw[idx];
		v2 = stack_msq[idx];
		r = '0;
		r.id = idx;
		r.cnt = n[15:0];
		r.rv = last;
		r.mre = mean_q16(stack_sr[idx], n);
		r.mim = mean_q16(stack_si[idx], n);
		if (siw != 0) begin
			wide = (128'(n * n) << 32) / siw;
			r.wgt = (wide > bsa_pkg::MASK48) ? bsa_pkg::MASK48[47:0] : wide[47:0];
		end
		if (n != 0) begin
			ar = (stack_sr[idx] < 0) ? -stack_sr[idx] : stack_sr[idx];
			ai = (stack_si[idx] < 0) ? -stack_si[idx] : stack_si[idx];
			wide = (ar * ar + ai * ai) / n;
			q = (wide[127:64] != 0) ? ALL64 : wide[63:0];
			contrib = (v2 > q) ? v2 - q : 64'd0;
			tsum = {1'b0, resid_total} + {1'b0, contrib};
			resid_total = tsum[64] ? ALL64 : tsum[63:0];
			csum = {1'b0, resid_cnt} + 33'(n);
			resid_cnt = csum[32] ? 32'hFFFF_FFFF : csum[31:0];
		end
		if (last) begin
			if (resid_cnt != 0) begin
				wide = (128'(resid_total) << 16) / resid_cnt;
				r.res = (wide > bsa_pkg::MASK48) ? bsa_pkg::MASK48[47:0] : wide[47:0];
			end
			resid_total = '0;
			resid_cnt = '0;
		end
		stack_sr[idx] = 0;
		stack_si[idx] = 0;
		stack_msq[idx] = '0;
		stack_siw[idx] = '0;
		stack_cnt[idx] = '0;
		return r;
	endfunction

	// input transfers: run the predictor and queue expected readouts
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			items_taken++;
			case (s_tuser)
				bsa_pkg::OP_FLAG: flag_ok[s_tdata[90:80]] = s_tdata[102];
				bsa_pkg::OP_ACC: accumulate(s_tdata[23:0], s_tdata[47:24], s_tdata[79:48],
					s_tdata[90:80], s_tdata[101:91], s_tdata[112:103], s_tdata[113]);
				bsa_pkg::OP_READ: begin
					stack_result_t r;
					r = read_stack(s_tdata[112:103], s_tlast);
					pending_results.push_back(cur_typed ? cur_exp : r);
				end
				default: ;
			endcase
		end
	end

	// output transfers: compare field by field with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			stack_result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result", m_tdata[63:0], '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[9:0] != want.id)
					report("stack_id", 64'(m_tdata[9:0]), 64'(want.id));
				if (m_tdata[49:10] != want.mre)
					report("mean_re", 64'(m_tdata[49:10]), 64'(want.mre));
				if (m_tdata[89:50] != want.mim)
					report("mean_im", 64'(m_tdata[89:50]), 64'(want.mim));
				if (m_tdata[137:90] != want.wgt)
					report("stack_weight", 64'(m_tdata[137:90]), 64'(want.wgt));
				if (m_tdata[153:138] != want.cnt)
					report("stack_count", 64'(m_tdata[153:138]), 64'(want.cnt));
				if (m_tdata[201:154] != want.res)
					report("residual", 64'(m_tdata[201:154]), 64'(want.res));
				if (m_tlast != want.rv)
					report("residual_valid", 64'(m_tlast), 64'(want.rv));
			end
		end
	end

	// receiver: random ready pattern, one long hold-off while the sender keeps offering
	initial begin
		bit held;
		int r;
		held = 0;
		m_tready = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (!held && items_taken >= 300) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (3000) @(negedge clk);
			end else if (r < 55) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end else if (r < 92) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(30, 400)) @(negedge clk);
			end
		end
	end

	// offer one item after a random gap and hold it until taken
	task automatic send_item(input bsa_item_t it);
		int r, gap;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 200);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tlast <= it.last;
		s_tdata <= {6'b0, it.conj, it.idx, it.fg, it.b, it.a, it.w, it.im, it.re};
		cur_typed <= it.typed;
		cur_exp <= it.exp;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic add_row(input logic [1:0] op, input logic [23:0] re, input logic [23:0] im,
			input logic [31:0] w, input logic [10:0] a, input logic [10:0] b, input logic fg,
			input logic [9:0] idx, input logic conj, input logic last,
			input logic typed, input stack_result_t exp);
		bsa_item_t it;
		it = {op, re, im, w, a, b, fg, idx, conj, last, typed, exp};
		directed_rows.push_back(it);
	endtask

	// random item: mostly products and readouts on a few busy stacks
	function automatic bsa_item_t random_item();
		bsa_item_t it;
		int r;
		it = '0;
		it.re = 24'($urandom);
		it.im = 24'($urandom);
		it.conj = 1'($urandom_range(0, 1));
		it.fg = ($urandom_range(0, 3) != 0);
		it.a = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 31)) : 11'($urandom);
		it.b = ($urandom_range(0, 9) < 7) ? 11'($urandom_range(0, 31)) : 11'($urandom);
		it.idx = ($urandom_range(0, 9) < 9) ? 10'($urandom_range(0, 15)) : 10'($urandom);
		it.last = ($urandom_range(0, 4) == 0);
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0: it.w = 32'd0;
			1: it.w = 32'hFFFF_FFFF;
			2, 3: it.w = $urandom;
			4: it.w = $urandom_range(1, 255);
			default: it.w = $urandom_range(32'h100, 32'h40000);
		endcase
		if (r < 10) it.op = bsa_pkg::OP_FLAG;
		else if (r < 70) it.op = bsa_pkg::OP_ACC;
		else if (r < 96) it.op = bsa_pkg::OP_READ;
		else it.op = OP_NONE;
		return it;
	endfunction

	// main sequence
	initial begin
		stack_result_t z;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = bsa_pkg::OP_FLAG;
		s_tlast = 1'b0;
		cur_typed = 1'b0;
		cur_exp = '0;
		foreach (flag_ok[i]) flag_ok[i] = 1'b1;
		foreach (stack_sr[i]) begin
			stack_sr[i] = 0;
			stack_si[i] = 0;
			stack_msq[i] = '0;
			stack_siw[i] = '0;
			stack_cnt[i] = '0;
		end
		resid_total = '0;
		resid_cnt = '0;

		// directed rows
		z = '0;
		// empty stack read out as last, with no totals
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd5, 0, 1, 1, '{5, 0, 0, 0, 0, 0, 1});
		// most negative real, conjugated most positive imaginary, weight 1.0
		add_row(bsa_pkg::OP_ACC, 24'h800000, 24'h7FFFFF, 32'h10000, 0, 1, 0, 10'd7, 1, 0, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd7, 0, 0, 1,
			'{7, 40'h80_0000_0000, 40'h80_0001_0000, 48'h1_0000, 1, 0, 0});
		// excluded input on either side, and zero weight, are skipped
		add_row(bsa_pkg::OP_FLAG, 0, 0, 0, 11'd3, 0, 0, 0, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd100, 24'd5, 32'h10000, 11'd3, 11'd4, 0, 10'd8, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd100, 24'd5, 32'h10000, 11'd4, 11'd3, 0, 10'd8, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd100, 24'd5, 32'd0, 11'd4, 11'd5, 0, 10'd8, 0, 0, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd8, 0, 0, 1, '{8, 0, 0, 0, 0, 0, 0});
		add_row(bsa_pkg::OP_FLAG, 0, 0, 0, 11'd3, 0, 1, 0, 0, 0, 0, z);
		// unused opcode with every field bit set
		add_row(OP_NONE, '1, '1, '1, '1, '1, 1, '1, 1, 1, 0, z);
		// top stack, top inputs, weight extremes
		add_row(bsa_pkg::OP_ACC, 24'h7FFFFF, 24'h800000, 32'hFFFF_FFFF, 11'd2047, 11'd2047, 0,
			10'd1023, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd1, 24'd0, 32'd1, 11'd2047, 11'd0, 0, 10'd1023, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'hFFFFFF, 24'hFFFFFF, 32'h7FFF_FFFF, 0, 0, 0, 10'd1023,
			1, 0, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd1023, 0, 0, 0, z);
		// spread of products, then last readout with a real residual
		add_row(bsa_pkg::OP_ACC, 24'd1000, 24'hFFFC18, 32'h20000, 6, 7, 0, 10'd2, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'hFFF830, 24'd300, 32'h8000, 6, 7, 0, 10'd2, 1, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd77, 24'd12345, 32'h10000, 6, 7, 0, 10'd2, 0, 0, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd2, 0, 1, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd2, 0, 1, 1, '{2, 0, 0, 0, 0, 0, 1});
		// top input excluded as second input
		add_row(bsa_pkg::OP_FLAG, 0, 0, 0, 11'd2047, 0, 0, 0, 0, 0, 0, z);
		add_row(bsa_pkg::OP_ACC, 24'd9, 24'd9, 32'h10000, 11'd5, 11'd2047, 0, 10'd9, 0, 0, 0, z);
		add_row(bsa_pkg::OP_FLAG, 0, 0, 0, 11'd2047, 0, 1, 0, 0, 0, 0, z);
		add_row(bsa_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 10'd9, 0, 0, 0, z);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) send_item(directed_rows[i]);
		repeat (1130) send_item(random_item());
		s_tvalid <= 1'b0;

		// drain
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report("results never arrived", 64'(pending_results.size()), 64'd0);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
